>>> sv/gtln_pkg.sv
// ----------------------------------------------------------------------------
// gtln_pkg
// Shared types and constants of the geodetic to local NED converter: fixed
// point constants, controller command and status groups, operand codes.
// ----------------------------------------------------------------------------
package gtln_pkg;

	// Scale fractions and the Q62 unit
	localparam int SCALE_FRAC_BITS = 32;
	localparam int Q_BITS          = 62;
	localparam int SERIES_TERMS    = 12;
	localparam int NEWTON_STEPS    = 5;

	localparam logic [63:0] ONE_Q      = 64'h4000_0000_0000_0000;
	localparam logic [63:0] THREE_Q    = 64'hC000_0000_0000_0000;
	localparam logic [63:0] PI_Q62     = 64'hC90F_DAA2_2168_C234;
	localparam logic [63:0] HALF_TURN  = 64'd1800000000;
	localparam logic [63:0] SEMI_MM    = 64'd6378137000;
	localparam logic [63:0] INV_FLAT   = 64'd298257223563;
	localparam logic [30:0] LAT_LIMIT  = 31'd900000000;

	// Radians per 1e-7 degree in Q62
	localparam logic [63:0] K_Q = PI_Q62 / HALF_TURN;

	// Flattening in Q62, long division in two decimal steps
	localparam logic [63:0] F_Q0 = ONE_Q / INV_FLAT;
	localparam logic [63:0] F_R0 = ONE_Q % INV_FLAT;
	localparam logic [63:0] F_Q1 = F_Q0 * 64'd10000 + (F_R0 * 64'd10000) / INV_FLAT;
	localparam logic [63:0] F_R1 = (F_R0 * 64'd10000) % INV_FLAT;
	localparam logic [63:0] F_Q  = F_Q1 * 64'd100000 + (F_R1 * 64'd100000) / INV_FLAT;

	// Rounded Q62 product of two constants
	function automatic logic [63:0] mulq_const(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (Q_BITS - 1));
		return p[Q_BITS +: 64];
	endfunction

	// Eccentricity squared
	localparam logic [63:0] E2_Q = (F_Q << 1) - mulq_const(F_Q, F_Q);

	// Product shift choices of the multiplier
	typedef enum logic [1:0] {
		SH_LOW,
		SH_Q,
		SH_RAD,
		SH_FRAC
	} shift_t;

	// Multiplier operand codes
	typedef enum logic [4:0] {
		SRC_ANG,
		SRC_K,
		SRC_X,
		SRC_X2,
		SRC_TERM,
		SRC_S,
		SRC_C,
		SRC_T,
		SRC_E2,
		SRC_W,
		SRC_Y,
		SRC_SEMI,
		SRC_RAD,
		SRC_NS,
		SRC_ES,
		SRC_DLAT,
		SRC_DLON
	} src_t;

	// Register updates applied by the datapath
	typedef enum logic [4:0] {
		ACT_NONE,
		ACT_CAPTURE,
		ACT_SET_X,
		ACT_SET_X2,
		ACT_SER_ACC,
		ACT_INIT_COS,
		ACT_CLAMP,
		ACT_SET_T,
		ACT_SET_W,
		ACT_NEWT_T,
		ACT_SET_Y,
		ACT_SET_RAD,
		ACT_SET_NS,
		ACT_SET_ES,
		ACT_ORIGIN_OUT,
		ACT_SET_NORTH,
		ACT_SET_EAST,
		ACT_FINISH
	} act_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_SQX,
		ST_SER_MUL,
		ST_SER_DIV,
		ST_COS_INIT,
		ST_CLAMP,
		ST_SS,
		ST_E2S,
		ST_NY2,
		ST_NW,
		ST_NY,
		ST_NMM,
		ST_NS,
		ST_ES,
		ST_ORIGIN,
		ST_NORTH,
		ST_EAST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       mul_go;
		src_t       src_a;
		src_t       src_b;
		shift_t     shift;
		logic       div_go;
		act_t       act;
		logic [3:0] iter;
		logic       cos_phase;
	} cmd_t;

	typedef struct packed {
		logic ref_valid;
		logic mul_done;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

>>> sv/geodetic_to_local_ned.sv
// ----------------------------------------------------------------------------
// geodetic_to_local_ned
// Flat-earth conversion of geodetic fixes to north, east, down offsets.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one fix per beat: latitude and
// longitude in 1e-7 degree, altitude in mm. Output channel (out_valid /
// out_stall) gives one result beat per fix: saturated north and east
// offsets, down offset in mm and an origin flag.
// The first fix after reset becomes the reference; it answers zero offsets
// with is_origin set. For it the sequencer runs the sine and cosine series
// and the Newton steps on one shared 64x64 multiplier (four 32x32 partial
// products a product step) and a reciprocal divider.
// Each later fix takes two products; one fix is in work at a time, and the
// next is taken once the result sits in the output register.
// Reset clears the reference, so the next fix becomes the origin again.
// A stalled result holds in the output register; a finished fix waits for
// it to drain before loading the next result.
// ----------------------------------------------------------------------------
module geodetic_to_local_ned (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [30:0]  latitude,
	input  logic signed [31:0]  longitude,
	input  logic signed [24:0]  altitude,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [35:0]  north_offset,
	output logic signed [35:0]  east_offset,
	output logic signed [24:0]  down_offset,
	output logic                is_origin
);

	gtln_pkg::cmd_t    cmd;
	gtln_pkg::status_t status;

	gtln_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	gtln_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.latitude     (latitude),
		.longitude    (longitude),
		.altitude     (altitude),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.north_offset (north_offset),
		.east_offset  (east_offset),
		.down_offset  (down_offset),
		.is_origin    (is_origin)
	);

endmodule

>>> sv/gtln_mul.sv
// ----------------------------------------------------------------------------
// gtln_mul
// Iterative 64x64 multiplier: four 32x32 partial products, then a rounding
// shift with saturation to 64 bits, or the plain low 64 bits.
// ----------------------------------------------------------------------------
module gtln_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [63:0]          a,
	input  logic [63:0]          b,
	input  gtln_pkg::shift_t     shift,
	output logic                 done,
	output logic [63:0]          result
);

	logic [63:0]      a_q;
	logic [63:0]      b_q;
	gtln_pkg::shift_t sh_q;
	logic [127:0]     acc_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [63:0]      res_q;

	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [63:0]  pp;
	logic [127:0] pp_shifted;
	logic [63:0]  final_res;

	// Round half up, shift down, saturate to all ones
	function automatic logic [63:0] round_shift(input logic [127:0] acc, input int s);
		logic [127:0] t;
		t = (acc + (128'd1 << (s - 1))) >> s;
		return (|t[127:64]) ? '1 : t[63:0];
	endfunction

	// Select the partial product of this step
	always_comb begin
		a_half = cnt_q[0] ? a_q[63:32] : a_q[31:0];
		b_half = cnt_q[1] ? b_q[63:32] : b_q[31:0];
		pp     = {32'd0, a_half} * {32'd0, b_half};
		unique case (cnt_q[1:0])
			2'd0:    pp_shifted = {64'd0, pp};
			2'd3:    pp_shifted = {pp, 64'd0};
			default: pp_shifted = {32'd0, pp, 32'd0};
		endcase
	end

	always_comb begin
		unique case (sh_q)
			gtln_pkg::SH_LOW:  final_res = acc_q[63:0];
			gtln_pkg::SH_Q:    final_res = round_shift(acc_q, gtln_pkg::Q_BITS);
			gtln_pkg::SH_RAD:  final_res = round_shift(acc_q,
				gtln_pkg::Q_BITS - gtln_pkg::SCALE_FRAC_BITS);
			gtln_pkg::SH_FRAC: final_res = round_shift(acc_q, gtln_pkg::SCALE_FRAC_BITS);
			default:           final_res = acc_q[63:0];
		endcase
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	// Accumulate partial products, then round
	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a;
			b_q   <= b;
			sh_q  <= shift;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				res_q <= final_res;
			end else begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> sv/gtln_div.sv
// ----------------------------------------------------------------------------
// gtln_div
// Divider by a series constant d = k * (k + 1): multiply by a stored
// reciprocal over four 32x32 partial products, then correct the estimate.
// ----------------------------------------------------------------------------
module gtln_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] dividend,
	input  logic [9:0]  divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0]  num_q;
	logic [63:0]  rcp_q;
	logic [9:0]   den_q;
	logic [127:0] acc_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  quot_q;

	logic [31:0]  a_half;
	logic [31:0]  b_half;
	logic [63:0]  pp;
	logic [127:0] pp_shifted;
	logic [63:0]  q_est;
	logic [21:0]  prod_lo;
	logic [10:0]  rem_lo;
	logic [63:0]  q_fix;

	// Reciprocal floor((2^64 - 1) / d) for each series divisor
	function automatic logic [63:0] recip(input logic [9:0] d);
		logic [63:0] r;
		r = '0;
		for (int k = 1; k <= 2 * gtln_pkg::SERIES_TERMS; k++) begin
			if (d == 10'(k * (k + 1))) begin
				r = {64{1'b1}} / 64'(k * (k + 1));
			end
		end
		return r;
	endfunction

	// Partial product of this step; the estimate is low by at most one,
	// so the low bits of the remainder decide the correction
	always_comb begin
		a_half = cnt_q[0] ? num_q[63:32] : num_q[31:0];
		b_half = cnt_q[1] ? rcp_q[63:32] : rcp_q[31:0];
		pp     = {32'd0, a_half} * {32'd0, b_half};
		unique case (cnt_q[1:0])
			2'd0:    pp_shifted = {64'd0, pp};
			2'd3:    pp_shifted = {pp, 64'd0};
			default: pp_shifted = {32'd0, pp, 32'd0};
		endcase
		q_est   = acc_q[127:64];
		prod_lo = {11'd0, q_est[10:0]} * {12'd0, den_q};
		rem_lo  = num_q[10:0] - prod_lo[10:0];
		q_fix   = q_est + {63'd0, (rem_lo >= {1'b0, den_q})};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	// Accumulate the reciprocal product, then correct the quotient
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			rcp_q <= recip(divisor);
			den_q <= divisor;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				quot_q <= q_fix;
			end else begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

>>> sv/gtln_datapath.sv
// ----------------------------------------------------------------------------
// gtln_datapath
// Working registers, reference fix, scales and output register, with the
// shared multiplier and divider. Driven by the controller's commands.
// ----------------------------------------------------------------------------
module gtln_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gtln_pkg::cmd_t       cmd,
	output gtln_pkg::status_t    status,
	input  logic signed [30:0]   latitude,
	input  logic signed [31:0]   longitude,
	input  logic signed [24:0]   altitude,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [35:0]   north_offset,
	output logic signed [35:0]   east_offset,
	output logic signed [24:0]   down_offset,
	output logic                 is_origin
);

	logic [30:0] lat_q;
	logic [31:0] lon_q;
	logic [24:0] alt_q;
	logic [30:0] ref_lat_q;
	logic [31:0] ref_lon_q;
	logic [24:0] ref_alt_q;
	logic        ref_valid_q;
	logic [47:0] ns_q;
	logic [47:0] es_q;
	logic [63:0] x_q;
	logic [63:0] x2_q;
	logic [63:0] term_q;
	logic [63:0] s_q;
	logic [63:0] c_q;
	logic [63:0] t_q;
	logic [63:0] w_q;
	logic [63:0] y_q;
	logic [63:0] rad_q;
	logic [35:0] north_q;
	logic [35:0] east_q;
	logic        out_valid_q;
	logic [35:0] north_out_q;
	logic [35:0] east_out_q;
	logic [24:0] down_out_q;
	logic        origin_out_q;

	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic        mul_done;
	logic [63:0] mul_res;
	logic        div_done;
	logic [63:0] quot;
	logic [9:0]  divisor;
	logic [4:0]  div_lo;

	logic [30:0] lat_abs;
	logic [30:0] ang;
	logic [31:0] dlat;
	logic [31:0] dlat_mag;
	logic [32:0] dlon;
	logic [32:0] dlon_mag;
	logic [25:0] dd;
	logic [24:0] down_sat;
	logic        out_free;

	// Saturate a sign and magnitude to 36 bits
	function automatic logic [35:0] sat36(input logic neg, input logic [63:0] mag);
		logic [63:0] lim;
		logic [63:0] m;
		lim = 64'd1 << 35;
		m   = mag;
		if (neg) begin
			if (m > lim) m = lim;
			m = 64'd0 - m;
		end else begin
			if (m > lim - 64'd1) m = lim - 64'd1;
		end
		return m[35:0];
	endfunction

	// Clamp a wrapped series sum to [0, 1]
	function automatic logic [63:0] clamp_unit(input logic [63:0] v);
		if (v[63]) return 64'd0;
		return (v > gtln_pkg::ONE_Q) ? gtln_pkg::ONE_Q : v;
	endfunction

	// Angle, deltas, down difference and series divisor
	always_comb begin
		lat_abs  = lat_q[30] ? (~lat_q + 31'd1) : lat_q;
		ang      = (lat_abs > gtln_pkg::LAT_LIMIT) ? gtln_pkg::LAT_LIMIT : lat_abs;
		dlat     = {lat_q[30], lat_q} - {ref_lat_q[30], ref_lat_q};
		dlat_mag = dlat[31] ? (~dlat + 32'd1) : dlat;
		dlon     = {lon_q[31], lon_q} - {ref_lon_q[31], ref_lon_q};
		dlon_mag = dlon[32] ? (~dlon + 33'd1) : dlon;
		dd       = {ref_alt_q[24], ref_alt_q} - {alt_q[24], alt_q};
		if (dd[25] == dd[24]) begin
			down_sat = dd[24:0];
		end else if (dd[25]) begin
			down_sat = {1'b1, 24'd0};
		end else begin
			down_sat = {1'b0, {24{1'b1}}};
		end
		div_lo  = cmd.cos_phase ? ({cmd.iter, 1'b0} - 5'd1) : {cmd.iter, 1'b0};
		divisor = {5'd0, div_lo} * ({5'd0, div_lo} + 10'd1);
	end

	// Operand selection
	function automatic logic [63:0] pick(input gtln_pkg::src_t s, input logic [63:0] ang64,
		input logic [63:0] dlat64, input logic [63:0] dlon64);
		logic [63:0] v;
		unique case (s)
			gtln_pkg::SRC_ANG:  v = ang64;
			gtln_pkg::SRC_K:    v = gtln_pkg::K_Q;
			gtln_pkg::SRC_X:    v = x_q;
			gtln_pkg::SRC_X2:   v = x2_q;
			gtln_pkg::SRC_TERM: v = term_q;
			gtln_pkg::SRC_S:    v = s_q;
			gtln_pkg::SRC_C:    v = c_q;
			gtln_pkg::SRC_T:    v = t_q;
			gtln_pkg::SRC_E2:   v = gtln_pkg::E2_Q;
			gtln_pkg::SRC_W:    v = w_q;
			gtln_pkg::SRC_Y:    v = y_q;
			gtln_pkg::SRC_SEMI: v = gtln_pkg::SEMI_MM;
			gtln_pkg::SRC_RAD:  v = rad_q;
			gtln_pkg::SRC_NS:   v = {16'd0, ns_q};
			gtln_pkg::SRC_ES:   v = {16'd0, es_q};
			gtln_pkg::SRC_DLAT: v = dlat64;
			gtln_pkg::SRC_DLON: v = dlon64;
			default:            v = 64'd0;
		endcase
		return v;
	endfunction

	always_comb begin
		mul_a = pick(cmd.src_a, {33'd0, ang}, {32'd0, dlat_mag}, {31'd0, dlon_mag});
		mul_b = pick(cmd.src_b, {33'd0, ang}, {32'd0, dlat_mag}, {31'd0, dlon_mag});
	end

	gtln_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.shift  (cmd.shift),
		.done   (mul_done),
		.result (mul_res)
	);

	gtln_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (mul_res),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quot)
	);

	assign out_free = !out_valid_q || !out_stall;

	// Apply register updates
	always_ff @(posedge clk) begin
		unique case (cmd.act)
			gtln_pkg::ACT_CAPTURE: begin
				lat_q <= latitude;
				lon_q <= longitude;
				alt_q <= altitude;
			end
			gtln_pkg::ACT_SET_X: x_q <= mul_res;
			gtln_pkg::ACT_SET_X2: begin
				x2_q   <= mul_res;
				term_q <= x_q;
				s_q    <= x_q;
			end
			gtln_pkg::ACT_SER_ACC: begin
				term_q <= quot;
				if (cmd.cos_phase) begin
					c_q <= cmd.iter[0] ? c_q - quot : c_q + quot;
				end else begin
					s_q <= cmd.iter[0] ? s_q - quot : s_q + quot;
				end
			end
			gtln_pkg::ACT_INIT_COS: begin
				term_q <= gtln_pkg::ONE_Q;
				c_q    <= gtln_pkg::ONE_Q;
			end
			gtln_pkg::ACT_CLAMP: begin
				s_q <= clamp_unit(s_q);
				c_q <= clamp_unit(c_q);
			end
			gtln_pkg::ACT_SET_T: t_q <= mul_res;
			gtln_pkg::ACT_SET_W: begin
				w_q <= gtln_pkg::ONE_Q - mul_res;
				y_q <= gtln_pkg::ONE_Q;
			end
			gtln_pkg::ACT_NEWT_T: t_q <= gtln_pkg::THREE_Q - mul_res;
			gtln_pkg::ACT_SET_Y: y_q <= {1'b0, mul_res[63:1]};
			gtln_pkg::ACT_SET_RAD: rad_q <= mul_res + {{39{alt_q[24]}}, alt_q};
			gtln_pkg::ACT_SET_NS: ns_q <= mul_res[47:0];
			gtln_pkg::ACT_SET_ES: es_q <= mul_res[47:0];
			gtln_pkg::ACT_ORIGIN_OUT: begin
				ref_lat_q    <= lat_q;
				ref_lon_q    <= lon_q;
				ref_alt_q    <= alt_q;
				north_out_q  <= '0;
				east_out_q   <= '0;
				down_out_q   <= '0;
				origin_out_q <= 1'b1;
			end
			gtln_pkg::ACT_SET_NORTH: north_q <= sat36(dlat[31], mul_res);
			gtln_pkg::ACT_SET_EAST: east_q <= sat36(dlon[32], mul_res);
			gtln_pkg::ACT_FINISH: begin
				north_out_q  <= north_q;
				east_out_q   <= east_q;
				down_out_q   <= down_sat;
				origin_out_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Reference flag and output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.act == gtln_pkg::ACT_ORIGIN_OUT) begin
				ref_valid_q <= 1'b1;
			end
			if (cmd.act == gtln_pkg::ACT_ORIGIN_OUT || cmd.act == gtln_pkg::ACT_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.ref_valid = ref_valid_q;
		status.mul_done  = mul_done;
		status.div_done  = div_done;
		status.out_free  = out_free;
	end

	assign out_valid    = out_valid_q;
	assign north_offset = north_out_q;
	assign east_offset  = east_out_q;
	assign down_offset  = down_out_q;
	assign is_origin    = origin_out_q;

endmodule

>>> sv/gtln_ctrl.sv
// ----------------------------------------------------------------------------
// gtln_ctrl
// Sequencer: steps the multiplier and divider through the scale derivation
// on the first fix and through the offset products on later fixes.
// ----------------------------------------------------------------------------
module gtln_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gtln_pkg::status_t status,
	output gtln_pkg::cmd_t    cmd
);

	gtln_pkg::state_t state_q;
	gtln_pkg::state_t state_d;
	logic [3:0]       iter_q;
	logic [3:0]       iter_d;
	logic             cos_q;
	logic             cos_d;
	logic             issued_q;
	logic             issued_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= gtln_pkg::ST_IDLE;
			iter_q   <= '0;
			cos_q    <= 1'b0;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			iter_q   <= iter_d;
			cos_q    <= cos_d;
			issued_q <= issued_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		iter_d        = iter_q;
		cos_d         = cos_q;
		in_stall      = 1'b1;
		cmd.mul_go    = 1'b0;
		cmd.src_a     = gtln_pkg::SRC_X;
		cmd.src_b     = gtln_pkg::SRC_X;
		cmd.shift     = gtln_pkg::SH_Q;
		cmd.div_go    = 1'b0;
		cmd.act       = gtln_pkg::ACT_NONE;
		cmd.iter      = iter_q;
		cmd.cos_phase = cos_q;
		unique case (state_q)
			gtln_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.act = gtln_pkg::ACT_CAPTURE;
					state_d = status.ref_valid ? gtln_pkg::ST_NORTH : gtln_pkg::ST_ANGLE;
				end
			end
			gtln_pkg::ST_ANGLE: begin
				cmd.src_a  = gtln_pkg::SRC_ANG;
				cmd.src_b  = gtln_pkg::SRC_K;
				cmd.shift  = gtln_pkg::SH_LOW;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_X;
					state_d = gtln_pkg::ST_SQX;
				end
			end
			gtln_pkg::ST_SQX: begin
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_X2;
					iter_d  = 4'd1;
					cos_d   = 1'b0;
					state_d = gtln_pkg::ST_SER_MUL;
				end
			end
			gtln_pkg::ST_SER_MUL: begin
				cmd.src_a  = gtln_pkg::SRC_TERM;
				cmd.src_b  = gtln_pkg::SRC_X2;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.div_go = 1'b1;
					state_d    = gtln_pkg::ST_SER_DIV;
				end
			end
			gtln_pkg::ST_SER_DIV: begin
				if (status.div_done) begin
					cmd.act = gtln_pkg::ACT_SER_ACC;
					if (iter_q == 4'(gtln_pkg::SERIES_TERMS)) begin
						state_d = cos_q ? gtln_pkg::ST_CLAMP : gtln_pkg::ST_COS_INIT;
					end else begin
						iter_d  = iter_q + 4'd1;
						state_d = gtln_pkg::ST_SER_MUL;
					end
				end
			end
			gtln_pkg::ST_COS_INIT: begin
				cmd.act = gtln_pkg::ACT_INIT_COS;
				iter_d  = 4'd1;
				cos_d   = 1'b1;
				state_d = gtln_pkg::ST_SER_MUL;
			end
			gtln_pkg::ST_CLAMP: begin
				cmd.act = gtln_pkg::ACT_CLAMP;
				state_d = gtln_pkg::ST_SS;
			end
			gtln_pkg::ST_SS: begin
				cmd.src_a  = gtln_pkg::SRC_S;
				cmd.src_b  = gtln_pkg::SRC_S;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_T;
					state_d = gtln_pkg::ST_E2S;
				end
			end
			gtln_pkg::ST_E2S: begin
				cmd.src_a  = gtln_pkg::SRC_E2;
				cmd.src_b  = gtln_pkg::SRC_T;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_W;
					iter_d  = 4'd0;
					state_d = gtln_pkg::ST_NY2;
				end
			end
			gtln_pkg::ST_NY2: begin
				cmd.src_a  = gtln_pkg::SRC_Y;
				cmd.src_b  = gtln_pkg::SRC_Y;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_T;
					state_d = gtln_pkg::ST_NW;
				end
			end
			gtln_pkg::ST_NW: begin
				cmd.src_a  = gtln_pkg::SRC_W;
				cmd.src_b  = gtln_pkg::SRC_T;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_NEWT_T;
					state_d = gtln_pkg::ST_NY;
				end
			end
			gtln_pkg::ST_NY: begin
				cmd.src_a  = gtln_pkg::SRC_Y;
				cmd.src_b  = gtln_pkg::SRC_T;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_Y;
					if (iter_q == 4'(gtln_pkg::NEWTON_STEPS - 1)) begin
						state_d = gtln_pkg::ST_NMM;
					end else begin
						iter_d  = iter_q + 4'd1;
						state_d = gtln_pkg::ST_NY2;
					end
				end
			end
			gtln_pkg::ST_NMM: begin
				cmd.src_a  = gtln_pkg::SRC_SEMI;
				cmd.src_b  = gtln_pkg::SRC_Y;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_RAD;
					state_d = gtln_pkg::ST_NS;
				end
			end
			gtln_pkg::ST_NS: begin
				cmd.src_a  = gtln_pkg::SRC_RAD;
				cmd.src_b  = gtln_pkg::SRC_K;
				cmd.shift  = gtln_pkg::SH_RAD;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_NS;
					state_d = gtln_pkg::ST_ES;
				end
			end
			gtln_pkg::ST_ES: begin
				cmd.src_a  = gtln_pkg::SRC_NS;
				cmd.src_b  = gtln_pkg::SRC_C;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_ES;
					state_d = gtln_pkg::ST_ORIGIN;
				end
			end
			gtln_pkg::ST_ORIGIN: begin
				if (status.out_free) begin
					cmd.act = gtln_pkg::ACT_ORIGIN_OUT;
					state_d = gtln_pkg::ST_IDLE;
				end
			end
			gtln_pkg::ST_NORTH: begin
				cmd.src_a  = gtln_pkg::SRC_DLAT;
				cmd.src_b  = gtln_pkg::SRC_NS;
				cmd.shift  = gtln_pkg::SH_FRAC;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_NORTH;
					state_d = gtln_pkg::ST_EAST;
				end
			end
			gtln_pkg::ST_EAST: begin
				cmd.src_a  = gtln_pkg::SRC_DLON;
				cmd.src_b  = gtln_pkg::SRC_ES;
				cmd.shift  = gtln_pkg::SH_FRAC;
				cmd.mul_go = !issued_q;
				if (status.mul_done) begin
					cmd.act = gtln_pkg::ACT_SET_EAST;
					state_d = gtln_pkg::ST_FINISH;
				end
			end
			gtln_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.act = gtln_pkg::ACT_FINISH;
					state_d = gtln_pkg::ST_IDLE;
				end
			end
			default: state_d = gtln_pkg::ST_IDLE;
		endcase
		// Track an outstanding multiply
		if (cmd.mul_go) begin
			issued_d = 1'b1;
		end else if (status.mul_done) begin
			issued_d = 1'b0;
		end else begin
			issued_d = issued_q;
		end
	end

endmodule

>>> bench/gtln_checker.sv
// ----------------------------------------------------------------------------
// gtln_checker
// Watches both channels of the geodetic to local NED converter, predicts
// each result beat from the accepted fixes and compares field by field.
// ----------------------------------------------------------------------------
module gtln_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic signed [24:0] altitude,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [35:0] north_offset,
	input  logic signed [35:0] east_offset,
	input  logic signed [24:0] down_offset,
	input  logic               is_origin,
	output int                 fails,
	output int                 pending,
	output int                 fixes_seen
);

	typedef struct {
		logic signed [35:0] north;
		logic signed [35:0] east;
		logic signed [24:0] down;
		logic               origin;
	} ned_t;

	ned_t ned_queue[$];

	// Reference copy
	logic        have_ref;
	longint      ref_lat;
	longint      ref_lon;
	longint      ref_alt;
	logic [47:0] n_scale;
	logic [47:0] e_scale;

	// round(a*b / 2^s), saturating to all ones
	function automatic logic [63:0] round_shift(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (s - 1));
		p = p >> s;
		if (p[127:64] != 0)
			return '1;
		return p[63:0];
	endfunction

	function automatic logic [63:0] unit_clamp(logic [63:0] v);
		if (v[63])
			return 64'd0;
		return (v > gtln_pkg::ONE_Q) ? gtln_pkg::ONE_Q : v;
	endfunction

	function automatic logic [63:0] sat_mag(logic neg, logic [63:0] mag, int w);
		logic [63:0] lim;
		lim = 64'd1 << (w - 1);
		if (neg)
			return (mag > lim) ? (64'd0 - lim) : (64'd0 - mag);
		return (mag > lim - 1) ? lim - 1 : mag;
	endfunction

	// Derive north and east scales from the reference fix
	task automatic derive_scales(longint lat, longint alt);
		longint      a;
		logic [63:0] x, x2, term, s, c, w, y, n_mm, radius;
		a = (lat < 0) ? -lat : lat;
		if (a > longint'(gtln_pkg::LAT_LIMIT))
			a = longint'(gtln_pkg::LAT_LIMIT);
		x = 64'(a) * gtln_pkg::K_Q;
		x2 = round_shift(x, x, gtln_pkg::Q_BITS);
		term = x;
		s = x;
		for (int i = 1; i <= gtln_pkg::SERIES_TERMS; i++) begin
			term = round_shift(term, x2, gtln_pkg::Q_BITS) / 64'((2 * i) * (2 * i + 1));
			s = (i & 1) ? s - term : s + term;
		end
		term = gtln_pkg::ONE_Q;
		c = gtln_pkg::ONE_Q;
		for (int i = 1; i <= gtln_pkg::SERIES_TERMS; i++) begin
			term = round_shift(term, x2, gtln_pkg::Q_BITS) / 64'((2 * i - 1) * (2 * i));
			c = (i & 1) ? c - term : c + term;
		end
		s = unit_clamp(s);
		c = unit_clamp(c);
		w = gtln_pkg::ONE_Q - round_shift(gtln_pkg::E2_Q,
			round_shift(s, s, gtln_pkg::Q_BITS), gtln_pkg::Q_BITS);
		y = gtln_pkg::ONE_Q;
		for (int i = 0; i < gtln_pkg::NEWTON_STEPS; i++)
			y = round_shift(y, gtln_pkg::THREE_Q - round_shift(w,
				round_shift(y, y, gtln_pkg::Q_BITS), gtln_pkg::Q_BITS),
				gtln_pkg::Q_BITS) >> 1;
		n_mm = round_shift(gtln_pkg::SEMI_MM, y, gtln_pkg::Q_BITS);
		radius = n_mm + 64'(alt);
		n_scale = 48'(round_shift(radius, gtln_pkg::K_Q,
			gtln_pkg::Q_BITS - gtln_pkg::SCALE_FRAC_BITS));
		e_scale = 48'(round_shift({16'd0, n_scale}, c, gtln_pkg::Q_BITS));
	endtask

	function automatic logic [35:0] scaled(longint delta, logic [47:0] scale);
		logic        neg;
		logic [63:0] mag;
		neg = delta < 0;
		mag = neg ? 64'd0 - 64'(delta) : 64'(delta);
		return 36'(sat_mag(neg, round_shift(mag, {16'd0, scale},
			gtln_pkg::SCALE_FRAC_BITS), 36));
	endfunction

	// Predict the result beat of one fix; the first fix sets the reference copy
	task automatic predict_ned(longint lat, longint lon, longint alt);
		ned_t   e;
		longint dd;
		if (!have_ref) begin
			have_ref = 1'b1;
			ref_lat = lat;
			ref_lon = lon;
			ref_alt = alt;
			derive_scales(lat, alt);
			e.north = '0;
			e.east = '0;
			e.down = '0;
			e.origin = 1'b1;
		end else begin
			e.north = scaled(lat - ref_lat, n_scale);
			e.east = scaled(lon - ref_lon, e_scale);
			dd = ref_alt - alt;
			e.down = 25'(sat_mag(dd < 0, (dd < 0) ? 64'(-dd) : 64'(dd), 25));
			e.origin = 1'b0;
		end
		ned_queue.push_back(e);
	endtask

	task automatic report(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	initial begin
		fails = 0;
		fixes_seen = 0;
		pending = 0;
		have_ref = 1'b0;
	end

	// Predict on each input beat, compare on each result beat
	always @(posedge clk) begin
		ned_t e;
		if (arst_n && in_valid && !in_stall) begin
			predict_ned(latitude, longitude, altitude);
			fixes_seen++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (ned_queue.size() == 0) begin
				$display("MISMATCH unexpected result beat at %0t", $realtime);
				fails++;
			end else begin
				e = ned_queue.pop_front();
				if (north_offset !== e.north)
					report("north_offset", north_offset, e.north);
				if (east_offset !== e.east)
					report("east_offset", east_offset, e.east);
				if (down_offset !== e.down)
					report("down_offset", down_offset, e.down);
				if (is_origin !== e.origin)
					report("is_origin", is_origin, e.origin);
			end
		end
		pending = ned_queue.size();
	end

endmodule

>>> bench/tb_geodetic_to_local_ned.sv
// ----------------------------------------------------------------------------
// tb_geodetic_to_local_ned
// Drives fixes into the converter with random gaps and result stalls; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_geodetic_to_local_ned;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic signed [24:0] altitude;
	logic               out_valid;
	logic               out_stall;
	logic signed [35:0] north_offset;
	logic signed [35:0] east_offset;
	logic signed [24:0] down_offset;
	logic               is_origin;

	int   fails;
	int   pending;
	int   fixes_seen;
	int   idle_cnt;
	logic no_gaps;
	logic [30:0] org_lat;
	logic [31:0] org_lon;
	logic [24:0] org_alt;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_FIXES   = 1250;

	geodetic_to_local_ned i_dut (.*);

	gtln_checker i_checker (
		.clk, .arst_n, .in_valid, .in_stall, .latitude, .longitude, .altitude,
		.out_valid, .out_stall, .north_offset, .east_offset, .down_offset,
		.is_origin, .fails, .pending, .fixes_seen
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: stall a random number of cycles before each beat
	initial begin
		int  n;
		logic took;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			n = no_gaps ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do begin
				@(negedge clk);
				took = out_valid;
				@(posedge clk);
			end while (!took);
		end
	end

	// Send one fix beat after a random gap; return at the accepting edge
	task automatic send_fix(logic [30:0] lat, logic [31:0] lon, logic [24:0] alt);
		int   gap;
		logic held;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		latitude <= lat;
		longitude <= lon;
		altitude <= alt;
		do begin
			@(negedge clk);
			held = in_stall;
			@(posedge clk);
		end while (held);
	endtask

	function automatic logic [30:0] near_lat(logic [30:0] base, int span);
		return base + 31'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	initial begin
		int pick;
		logic [30:0] lat;
		logic [31:0] lon;
		logic [24:0] alt;
		arst_n = 1'b0;
		in_valid = 1'b0;
		latitude = '0;
		longitude = '0;
		altitude = '0;
		no_gaps = 1'b0;
		idle_cnt = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Origin fix: one in four beyond the pole limit to hit the clamp
		if ($urandom_range(0, 3) == 0)
			org_lat = $urandom_range(0, 1) ? 31'sd1000000000 : -31'sd1073741824;
		else
			org_lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
		org_lon = $urandom;
		org_alt = 25'($signed($urandom_range(0, 9500000)) - 500000);
		send_fix(org_lat, org_lon, org_alt);

		// Directed corners: zero deltas, unit deltas, field extremes
		send_fix(org_lat, org_lon, org_alt);
		send_fix(org_lat + 31'd1, org_lon + 32'd1, org_alt + 25'd1);
		send_fix(org_lat - 31'd1, org_lon - 32'd1, org_alt - 25'd1);
		send_fix(31'sd900000000, 32'sd1800000000, 25'sd9000000);
		send_fix(-31'sd900000000, -32'sd1800000000, -25'sd500000);
		send_fix(31'h3FFF_FFFF, 32'h7FFF_FFFF, 25'h0FF_FFFF);
		send_fix(31'h4000_0000, 32'h8000_0000, 25'h100_0000);
		send_fix(31'h4000_0000, 32'h7FFF_FFFF, 25'h0FF_FFFF);
		send_fix(31'h3FFF_FFFF, 32'h8000_0000, 25'h100_0000);
		send_fix('0, '0, '0);
		send_fix('1, '1, '1);

		// Pause until the converter has drained everything
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);

		for (int i = 0; i < RANDOM_FIXES; i++) begin
			no_gaps = (i >= 400 && i < 500);
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				// Local moves around the reference
				lat = near_lat(org_lat, 2000000);
				lon = org_lon + 32'($signed($urandom_range(0, 4000000)) - 2000000);
				alt = org_alt + 25'($signed($urandom_range(0, 200000)) - 100000);
			end else if (pick < 9) begin
				// Any fix in the valid ranges
				lat = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
				lon = 32'($signed($urandom_range(0, 3600000000)) - 1800000000);
				alt = 25'($signed($urandom_range(0, 9500000)) - 500000);
			end else begin
				// Raw bit patterns over the full field widths
				lat = 31'($urandom);
				lon = $urandom;
				alt = 25'($urandom);
			end
			send_fix(lat, lon, alt);
		end
		no_gaps = 1'b0;
		in_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		$display("covered %0d fixes: origin latch, local and far moves, field extremes,",
			fixes_seen);
		$display("random gaps and stalls, one drain pause and a back-to-back stretch");
		if (fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
